@@ hdl/bbe_pkg.sv @@
package bbe_pkg;

   localparam int TAPE_CELLS = 32768;
   localparam int TAPE_AW    = $clog2(TAPE_CELLS);
   localparam int STEP_W     = 16;
   localparam int SUM_W      = ((TAPE_AW > STEP_W) ? TAPE_AW : STEP_W) + 1;

   localparam logic [3:0] CMD_RET   = 4'd0;
   localparam logic [3:0] CMD_ADDP  = 4'd1;
   localparam logic [3:0] CMD_SUBP  = 4'd2;
   localparam logic [3:0] CMD_ADDV  = 4'd3;
   localparam logic [3:0] CMD_SUBV  = 4'd4;
   localparam logic [3:0] CMD_WRITE = 4'd5;
   localparam logic [3:0] CMD_READ  = 4'd6;
   localparam logic [3:0] CMD_JMPZ  = 4'd7;
   localparam logic [3:0] CMD_JMPNZ = 4'd8;
   localparam logic [3:0] CMD_DEBUG = 4'd9;

   localparam logic [1:0] RS_BYTE = 2'd0;
   localparam logic [1:0] RS_EOF  = 2'd1;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_DONE    = 3'd1;
   localparam logic [2:0] ST_BOUNDS  = 3'd2;
   localparam logic [2:0] ST_EOF     = 3'd3;
   localparam logic [2:0] ST_IO      = 3'd4;
   localparam logic [2:0] ST_INVALID = 3'd5;

   typedef enum logic [2:0] {
      OP_STATUS,
      OP_ADDP,
      OP_SUBP,
      OP_ADDC,
      OP_SETC,
      OP_WRITE,
      OP_JMPZ,
      OP_JMPNZ
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [2:0]         status;
      logic [STEP_W-1:0]  step;
      logic [7:0]         value;
      logic [23:0]        target;
   } entry_type;

endpackage

@@ hdl/bbe_if.sv @@
interface bbe_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  command;
   logic [15:0] step_amount;
   logic [23:0] jump_target;
   logic [7:0]  in_byte;
   logic [1:0]  in_status;

   modport source (output valid, command, step_amount, jump_target, in_byte, in_status,
                   input ready);
   modport sink (input valid, command, step_amount, jump_target, in_byte, in_status,
                 output ready);
endinterface

interface bbe_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic        out_valid;
   logic [7:0]  out_byte;
   logic        jump_taken;
   logic [23:0] jump_dest;

   modport source (output valid, status, out_valid, out_byte, jump_taken, jump_dest,
                   input ready);
   modport sink (input valid, status, out_valid, out_byte, jump_taken, jump_dest,
                 output ready);
endinterface

@@ hdl/bbe_front.sv @@
module bbe_front (
   bbe_req_if.sink            req,
   input  logic               accept_ok,
   output logic               push,
   output bbe_pkg::entry_type entry
);

   assign req.ready = accept_ok;
   assign push      = req.valid && accept_ok;

   always_comb begin
      entry.op     = bbe_pkg::OP_STATUS;
      entry.status = bbe_pkg::ST_OK;
      entry.step   = req.step_amount;
      entry.value  = req.step_amount[7:0];
      entry.target = req.jump_target;
      case (req.command)
         bbe_pkg::CMD_RET: begin
            entry.status = bbe_pkg::ST_DONE;
         end
         bbe_pkg::CMD_ADDP: begin
            entry.op = bbe_pkg::OP_ADDP;
         end
         bbe_pkg::CMD_SUBP: begin
            entry.op = bbe_pkg::OP_SUBP;
         end
         bbe_pkg::CMD_ADDV: begin
            entry.op = bbe_pkg::OP_ADDC;
         end
         bbe_pkg::CMD_SUBV: begin
            entry.op    = bbe_pkg::OP_ADDC;
            entry.value = ~req.step_amount[7:0] + 8'd1;
         end
         bbe_pkg::CMD_WRITE: begin
            entry.op = bbe_pkg::OP_WRITE;
         end
         bbe_pkg::CMD_READ: begin
            entry.value = req.in_byte;
            if (req.in_status == bbe_pkg::RS_BYTE) begin
               entry.op = bbe_pkg::OP_SETC;
            end else if (req.in_status == bbe_pkg::RS_EOF) begin
               entry.status = bbe_pkg::ST_EOF;
            end else begin
               entry.status = bbe_pkg::ST_IO;
            end
         end
         bbe_pkg::CMD_JMPZ: begin
            entry.op = bbe_pkg::OP_JMPZ;
         end
         bbe_pkg::CMD_JMPNZ: begin
            entry.op = bbe_pkg::OP_JMPNZ;
         end
         bbe_pkg::CMD_DEBUG: begin
            entry.status = bbe_pkg::ST_OK;
         end
         default: begin
            entry.status = bbe_pkg::ST_INVALID;
         end
      endcase
   end

endmodule

@@ hdl/bbe_queue.sv @@
module bbe_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  bbe_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output bbe_pkg::entry_type head_entry
);

   bbe_pkg::entry_type slot_ff [2];
   logic               wr_ptr_ff;
   logic               wr_ptr_in;
   logic               rd_ptr_ff;
   logic               rd_ptr_in;
   logic [1:0]         count_ff;
   logic [1:0]         count_in;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ hdl/bbe_back.sv @@
module bbe_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  bbe_pkg::entry_type head_entry,
   output logic               pop,
   output logic               clear_done,
   bbe_rsp_if.source          rsp
);

   localparam int AW = bbe_pkg::TAPE_AW;
   localparam int SW = bbe_pkg::SUM_W;

   logic [7:0]    tape_mem [bbe_pkg::TAPE_CELLS];
   logic [AW:0]   clr_cnt_ff;
   logic [AW-1:0] dp_ff;
   logic [AW-1:0] dp_in;
   logic [7:0]    cell_ff;
   logic [7:0]    cell_in;
   logic          fresh_ff;
   logic          fresh_in;
   logic [7:0]    rd_data_ff;
   logic [7:0]    cur_cell;
   logic          wr_en;
   logic [SW-1:0] sum;
   logic [SW-1:0] diff;
   logic          exec;

   logic          rsp_valid_ff;
   logic [2:0]    status_ff;
   logic [2:0]    status_in;
   logic          out_valid_ff;
   logic          out_valid_in;
   logic [7:0]    out_byte_ff;
   logic [7:0]    out_byte_in;
   logic          taken_ff;
   logic          taken_in;
   logic [23:0]   dest_ff;
   logic [23:0]   dest_in;

   assign clear_done = clr_cnt_ff[AW];
   assign cur_cell   = fresh_ff ? rd_data_ff : cell_ff;
   assign exec       = head_valid && clear_done && (!rsp_valid_ff || rsp.ready);
   assign pop        = exec;

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.status     = status_ff;
   assign rsp.out_valid  = out_valid_ff;
   assign rsp.out_byte   = out_byte_ff;
   assign rsp.jump_taken = taken_ff;
   assign rsp.jump_dest  = dest_ff;

   always_comb begin
      sum          = SW'(dp_ff) + SW'(head_entry.step);
      diff         = SW'(dp_ff) - SW'(head_entry.step);
      dp_in        = dp_ff;
      cell_in      = cell_ff;
      fresh_in     = fresh_ff;
      wr_en        = 1'b0;
      status_in    = bbe_pkg::ST_OK;
      out_valid_in = 1'b0;
      out_byte_in  = 8'd0;
      taken_in     = 1'b0;
      dest_in      = 24'd0;
      case (head_entry.op)
         bbe_pkg::OP_STATUS: begin
            status_in = head_entry.status;
         end
         bbe_pkg::OP_ADDP: begin
            if (sum >= SW'(bbe_pkg::TAPE_CELLS)) begin
               status_in = bbe_pkg::ST_BOUNDS;
            end else begin
               dp_in    = sum[AW-1:0];
               fresh_in = 1'b1;
            end
         end
         bbe_pkg::OP_SUBP: begin
            if (SW'(head_entry.step) > SW'(dp_ff)) begin
               status_in = bbe_pkg::ST_BOUNDS;
            end else begin
               dp_in    = diff[AW-1:0];
               fresh_in = 1'b1;
            end
         end
         bbe_pkg::OP_ADDC: begin
            cell_in  = cur_cell + head_entry.value;
            fresh_in = 1'b0;
            wr_en    = 1'b1;
         end
         bbe_pkg::OP_SETC: begin
            cell_in  = head_entry.value;
            fresh_in = 1'b0;
            wr_en    = 1'b1;
         end
         bbe_pkg::OP_WRITE: begin
            out_valid_in = 1'b1;
            out_byte_in  = cur_cell;
         end
         bbe_pkg::OP_JMPZ: begin
            if (cur_cell == 8'd0) begin
               taken_in = 1'b1;
               dest_in  = head_entry.target;
            end
         end
         bbe_pkg::OP_JMPNZ: begin
            if (cur_cell != 8'd0) begin
               taken_in = 1'b1;
               dest_in  = head_entry.target;
            end
         end
         default: begin
            status_in = bbe_pkg::ST_INVALID;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff   <= '0;
         dp_ff        <= '0;
         cell_ff      <= 8'd0;
         fresh_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (!clear_done) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
         end
         if (exec) begin
            dp_ff        <= dp_in;
            cell_ff      <= cell_in;
            fresh_ff     <= fresh_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (exec) begin
         status_ff    <= status_in;
         out_valid_ff <= out_valid_in;
         out_byte_ff  <= out_byte_in;
         taken_ff     <= taken_in;
         dest_ff      <= dest_in;
      end
   end

   // The read port always follows the pointer, so the word is ready the cycle after a move.
   always_ff @(posedge clock) begin
      if (!clear_done) begin
         tape_mem[clr_cnt_ff[AW-1:0]] <= 8'd0;
      end else if (exec && wr_en) begin
         tape_mem[dp_ff] <= cell_in;
      end
      rd_data_ff <= tape_mem[exec ? dp_in : dp_ff];
   end

endmodule

@@ hdl/brainfuck_bytecode_executor.sv @@
// Executes one decoded bytecode instruction per request beat and returns one response
// beat for each, in order.
// The req_bus channel carries the command, the pointer or cell step, the jump target
// and the input byte with its status. The rsp_bus channel carries the status code, the
// output byte with its flag, and the jump decision with its destination.
// An accepted request is decoded into a two-entry queue; the execute stage takes the
// queue head, updates the data pointer and the 32768-byte tape, and loads the response
// register. A request thus passes through a queue slot and then the response register,
// and one beat can be accepted and returned every cycle while rsp_bus.ready stays high.
// The current cell sits in a register, with the tape's registered read port following
// the pointer, so a pointer move and a use of the new cell can run back to back.
// After reset the tape is cleared one byte per cycle; during that pass req_bus.ready
// stays low. The pointer starts at zero.
// When the receiver holds rsp_bus.ready low, the response register holds its beat,
// the execute stage waits, and the queue accepts up to two more requests before
// req_bus.ready drops.
module brainfuck_bytecode_executor (
   input logic       clock,
   input logic       reset,
   bbe_req_if.sink   req_bus,
   bbe_rsp_if.source rsp_bus
);

   logic               push;
   logic               q_full;
   logic               pop;
   logic               head_valid;
   logic               clear_done;
   bbe_pkg::entry_type push_entry;
   bbe_pkg::entry_type head_entry;

   bbe_front u_front (
      .req        (req_bus),
      .accept_ok  (clear_done && !q_full),
      .push       (push),
      .entry      (push_entry)
   );

   bbe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   bbe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .clear_done (clear_done),
      .rsp        (rsp_bus)
   );

endmodule
